// ===== rtl/core/rscpu_pkg.sv =====
// Shared types and constants of the register machine execution unit.
`default_nettype none
package rscpu_pkg;
    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_ADD2 = 5'd1, OP_SUB = 5'd2, OP_SUB2 = 5'd3,
        OP_DIV = 5'd4, OP_DIV2 = 5'd5, OP_MUL = 5'd6, OP_MUL2 = 5'd7,
        OP_MOV = 5'd8, OP_MOV2 = 5'd9, OP_CMP = 5'd10, OP_CMP2 = 5'd11,
        OP_POP = 5'd12, OP_PUSH = 5'd13, OP_CALL = 5'd14, OP_JP = 5'd15,
        OP_JA = 5'd16, OP_JB = 5'd17, OP_JAE = 5'd18, OP_JBE = 5'd19,
        OP_JE = 5'd20, OP_JZ = 5'd21, OP_JNZ = 5'd22, OP_RET = 5'd23,
        OP_OUT = 5'd24, OP_IN = 5'd25, OP_CLR = 5'd26, OP_DEC = 5'd27,
        OP_INC = 5'd28, OP_NOP = 5'd29, OP_END = 5'd30, OP_UNUSED = 5'd31
    } opcode_t;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_DIV0  = 3'd1;
    localparam logic [2:0] ERR_FULL  = 3'd2;
    localparam logic [2:0] ERR_EMPTY = 3'd3;
    localparam logic [2:0] ERR_REG   = 3'd4;

    localparam int FLAG_GT = 0;
    localparam int FLAG_LT = 1;
    localparam int FLAG_EQ = 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic mul_done;
        logic div_start;
        logic div_step;
        logic div_commit;
    } ctrl_t;

    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_last;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/register_stack_cpu_execute_top.sv =====
// Top level of the register machine execution unit.
// Each input transfer on s_* carries one fetched instruction; each output
// transfer on m_* carries its result: next PC, OUT value and flag, halt flag
// and error code. Exactly one result follows every instruction, in order.
// A result is offered in the OUT state after its instruction passes READ,
// then MUL for multiply or the DIV steps of the one-bit-per-cycle restoring
// divider for divide, and then EXEC. The unit works on one instruction at a
// time and takes no new instruction until the last result is sent. A new
// instruction is accepted in the same cycle as the pending result transfer
// completes.
// If the receiver stalls, the result holds on m_tdata and no new
// instruction is taken. Reset clears the registers, flags, PC and stack
// pointer; stack entries are undefined until pushed.
`default_nettype none
module register_stack_cpu_execute_top
    import rscpu_pkg::*;
#(
    parameter int REG_COUNT   = 16,
    parameter int STACK_DEPTH = 64,
    parameter int DATA_BITS   = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[4:0], first_word[20:5], second_word[36:21], in_value[68:37]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // next_pc[15:0], out_value[47:16], out_valid[48], halted[49], error_code[52:50]
    output logic [55:0]      m_tdata
);
    ctrl_t ctrl;
    stat_t stat;
    logic [15:0] next_pc;
    logic [31:0] out_value;
    logic out_valid, halted;
    logic [2:0] error_code;

    rscpu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .ctrl(ctrl)
    );

    rscpu_datapath #(
        .REG_COUNT(REG_COUNT), .STACK_DEPTH(STACK_DEPTH), .DATA_BITS(DATA_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .opcode(s_tdata[4:0]), .first_word(s_tdata[20:5]),
        .second_word(s_tdata[36:21]), .in_value(s_tdata[68:37]),
        .next_pc(next_pc), .out_value(out_value), .out_valid(out_valid),
        .halted(halted), .error_code(error_code)
    );

    assign m_tdata = {3'd0, error_code, halted, out_valid, out_value, next_pc};
endmodule
`default_nettype wire

// ===== rtl/core/rscpu_ctrl.sv =====
// Controller state machine that sequences one instruction through the datapath.
`default_nettype none
module rscpu_ctrl
    import rscpu_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.load = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ctrl.read = 1'b1;
                if (stat.need_div) begin
                    state_next = ST_DIV;
                    ctrl.div_start = 1'b1;
                end else if (stat.need_mul) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_MUL: begin
                ctrl.mul_done = 1'b1;
                state_next = ST_EXEC;
            end
            ST_DIV: begin
                if (stat.div_last) begin
                    ctrl.div_commit = 1'b1;
                    state_next = ST_EXEC;
                end else begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_EXEC: begin
                ctrl.exec = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
                if (m_tready) begin
                    if (s_tvalid) begin
                        ctrl.load = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/rscpu_datapath.sv =====
// Datapath with register file, flags, stack memory, multiplier and serial divider.
`default_nettype none
module rscpu_datapath
    import rscpu_pkg::*;
#(
    parameter int REG_COUNT   = 16,
    parameter int STACK_DEPTH = 64,
    parameter int DATA_BITS   = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ctrl_t       ctrl,
    output stat_t            stat,
    input  wire logic [4:0]  opcode,
    input  wire logic [15:0] first_word,
    input  wire logic [15:0] second_word,
    input  wire logic [31:0] in_value,
    output logic [15:0]      next_pc,
    output logic [31:0]      out_value,
    output logic             out_valid,
    output logic             halted,
    output logic [2:0]       error_code
);
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(DATA_BITS + 1);
    localparam int HW = (DATA_BITS < 32) ? DATA_BITS : 32;
    localparam int WIDE = (DATA_BITS > 16) ? DATA_BITS : 16;

    logic [DATA_BITS-1:0] regs_reg [REG_COUNT];
    logic [DATA_BITS-1:0] stack_mem [STACK_DEPTH];
    logic [2:0]  flags_reg;
    logic [15:0] pc_reg;
    logic [PW-1:0] sp_reg;

    opcode_t op_reg;
    logic [15:0] a_reg, b_reg;
    logic [DATA_BITS-1:0] inv_reg, dst_reg, src_reg, stk_reg, res_reg;
    logic [DATA_BITS-1:0] quo_reg, rem_reg;
    logic [CW-1:0] cnt_reg;

    logic [15:0] next_pc_reg;
    logic [31:0] out_value_reg;
    logic out_valid_reg, halted_reg;
    logic [2:0] err_reg;

    opcode_t op_in;
    logic two_reg, reg_imm, one_reg, a_ok, b_ok;
    logic [RW-1:0] ai, bi;
    logic [DATA_BITS-1:0] imm;
    logic [SW-1:0] pop_addr;

    assign op_in = opcode_t'(op_reg);
    assign two_reg = (op_reg <= OP_CMP) && !op_reg[0];
    assign reg_imm = (op_reg <= OP_CMP2) && op_reg[0];
    assign one_reg = (op_reg == OP_POP) || (op_reg == OP_PUSH)
                     || ((op_reg >= OP_OUT) && (op_reg <= OP_INC));
    assign a_ok = {16'd0, a_reg} < 32'(REG_COUNT);
    assign b_ok = {16'd0, b_reg} < 32'(REG_COUNT);
    assign ai = a_ok ? a_reg[RW-1:0] : '0;
    assign bi = b_ok ? b_reg[RW-1:0] : '0;
    assign imm = DATA_BITS'(WIDE'(b_reg));
    assign pop_addr = SW'(sp_reg - PW'(1));

    assign stat.need_mul = (op_reg == OP_MUL) || (op_reg == OP_MUL2);
    assign stat.need_div = ((op_reg == OP_DIV) || (op_reg == OP_DIV2));
    assign stat.div_last = (cnt_reg == CW'(DATA_BITS));

    logic [DATA_BITS:0] rem_sh;
    assign rem_sh = {rem_reg, quo_reg[DATA_BITS-1]};

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            op_reg <= opcode_t'(opcode);
            a_reg <= first_word;
            b_reg <= second_word;
            inv_reg <= DATA_BITS'(WIDE'(in_value));
        end
        if (ctrl.read) begin
            dst_reg <= regs_reg[ai];
            src_reg <= two_reg ? regs_reg[bi] : imm;
            stk_reg <= stack_mem[pop_addr];
        end
        if (ctrl.mul_done) begin
            res_reg <= DATA_BITS'(dst_reg * src_reg);
        end
        if (ctrl.div_start) begin
            quo_reg <= regs_reg[ai];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (ctrl.div_step) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (rem_sh >= {1'b0, src_reg}) begin
                rem_reg <= DATA_BITS'(rem_sh - {1'b0, src_reg});
                quo_reg <= {quo_reg[DATA_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DATA_BITS-1:0];
                quo_reg <= {quo_reg[DATA_BITS-2:0], 1'b0};
            end
        end
        if (ctrl.div_commit) begin
            res_reg <= quo_reg;
        end
    end

    logic [2:0] err;
    logic jump, wr_reg, wr_flags, push, pop, halt, outok;
    logic [DATA_BITS-1:0] wval, pval;
    logic [2:0] nflags;
    logic [15:0] len, target, next;
    logic sp_full, sp_empty;

    assign sp_full = sp_reg >= PW'(STACK_DEPTH);
    assign sp_empty = sp_reg == '0;

    always_comb begin
        err = ERR_NONE;
        jump = 1'b0;
        wr_reg = 1'b0;
        wr_flags = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        halt = 1'b0;
        outok = 1'b0;
        wval = '0;
        pval = dst_reg;
        nflags = 3'b000;
        target = a_reg;
        len = 16'd1;
        if (two_reg || reg_imm) begin
            len = 16'd3;
        end else if (one_reg || ((op_reg >= OP_CALL) && (op_reg <= OP_JE))) begin
            len = 16'd2;
        end
        if ((two_reg || reg_imm || one_reg) && !a_ok) begin
            err = ERR_REG;
        end else if (two_reg && !b_ok) begin
            err = ERR_REG;
        end else begin
            case (op_in)
                OP_ADD, OP_ADD2: begin wr_reg = 1'b1; wval = dst_reg + src_reg; end
                OP_SUB, OP_SUB2: begin wr_reg = 1'b1; wval = dst_reg - src_reg; end
                OP_DIV, OP_DIV2: begin
                    if (src_reg == '0) err = ERR_DIV0;
                    else begin wr_reg = 1'b1; wval = res_reg; end
                end
                OP_MUL, OP_MUL2: begin wr_reg = 1'b1; wval = res_reg; end
                OP_MOV, OP_MOV2: begin wr_reg = 1'b1; wval = src_reg; end
                OP_CMP, OP_CMP2: begin
                    wr_flags = 1'b1;
                    if (dst_reg > src_reg) nflags[FLAG_GT] = 1'b1;
                    else if (dst_reg < src_reg) nflags[FLAG_LT] = 1'b1;
                    else nflags[FLAG_EQ] = 1'b1;
                end
                OP_POP: begin
                    if (sp_empty) err = ERR_EMPTY;
                    else begin pop = 1'b1; wr_reg = 1'b1; wval = stk_reg; end
                end
                OP_PUSH: begin
                    if (sp_full) err = ERR_FULL;
                    else push = 1'b1;
                end
                OP_CALL: begin
                    if (sp_full) err = ERR_FULL;
                    else begin
                        push = 1'b1;
                        jump = 1'b1;
                        pval = DATA_BITS'(WIDE'(pc_reg + 16'd2));
                    end
                end
                OP_JP: jump = 1'b1;
                OP_JA: jump = flags_reg[FLAG_GT];
                OP_JB: jump = flags_reg[FLAG_LT];
                OP_JAE: jump = flags_reg[FLAG_GT] | flags_reg[FLAG_EQ];
                OP_JBE: jump = flags_reg[FLAG_LT] | flags_reg[FLAG_EQ];
                OP_JE: jump = flags_reg[FLAG_EQ];
                OP_RET: begin
                    if (sp_empty) err = ERR_EMPTY;
                    else begin
                        pop = 1'b1;
                        jump = 1'b1;
                        target = 16'(WIDE'(stk_reg));
                    end
                end
                OP_OUT: outok = 1'b1;
                OP_IN: begin wr_reg = 1'b1; wval = inv_reg; end
                OP_CLR: begin wr_reg = 1'b1; wval = '0; end
                OP_DEC: begin wr_reg = 1'b1; wval = dst_reg - DATA_BITS'(1); end
                OP_INC: begin wr_reg = 1'b1; wval = dst_reg + DATA_BITS'(1); end
                OP_END: halt = 1'b1;
                default: ;
            endcase
        end
        if ((err != ERR_NONE) || halt) next = pc_reg;
        else if (jump) next = target;
        else next = pc_reg + len;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec && wr_reg) begin
            regs_reg[ai] <= wval;
        end
        if (ctrl.exec && push) begin
            stack_mem[sp_reg[SW-1:0]] <= pval;
        end
        if (ctrl.exec) begin
            next_pc_reg <= next;
            out_value_reg <= outok ? 32'(dst_reg[HW-1:0]) : 32'd0;
            out_valid_reg <= outok;
            halted_reg <= halt;
            err_reg <= err;
        end
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) regs_reg[i] <= '0;
            flags_reg <= '0;
            pc_reg <= '0;
            sp_reg <= '0;
        end else if (ctrl.exec) begin
            pc_reg <= next;
            if (wr_flags) flags_reg <= nflags;
            if (push) sp_reg <= sp_reg + PW'(1);
            else if (pop) sp_reg <= sp_reg - PW'(1);
        end
    end

    assign next_pc = next_pc_reg;
    assign out_value = out_value_reg;
    assign out_valid = out_valid_reg;
    assign halted = halted_reg;
    assign error_code = err_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rscpu_checker.sv =====
// Port-level checker for the execution unit, bound to the top level.
`default_nettype none
module rscpu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    a_no_accept_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
    a_halt_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[49] && (m_tdata[52:50] != 3'd0)))
        else $error("halt reported with an error");
endmodule

bind register_stack_cpu_execute_top rscpu_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
